[sv/dha_pkg.sv]
`timescale 1ns / 1ps

package dha_pkg;

    // field widths
    localparam int HANDLE_W = 10;
    localparam int COUNT_W  = 11;
    localparam int FUNC_W   = 2;

    // size of the 10-bit handle space
    localparam int HANDLE_SPACE = 1 << HANDLE_W;

    // default table depth
    localparam int MAX_HANDLES_DEF = 1024;

    // capacity register after reset
    localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(1024);

    // stream payload widths, rounded to whole bytes
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_CHECK = 2'd2,
        FN_READ  = 2'd3
    } func_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_READ,
        ST_POS,
        ST_CHK,
        ST_LAST,
        ST_TAIL,
        ST_DONE
    } state_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic  take;
        func_t func;
        logic  live;
        logic  out_free;
    } dha_stat_t;

    // control from the sequencer to the datapath
    typedef struct packed {
        state_t state;
        func_t  func;
        logic   in_ready;
    } dha_ctl_t;

endpackage

[sv/dense_handle_allocator_top.sv]
`timescale 1ns / 1ps
// Dense handle allocator: hands out and takes back 10-bit handles, kept as a
// dense table of handles (live ones first) and a reverse table from handle to
// dense position, plus a live count. Each input beat carries an operation
// (allocate, free, check live, read at position) and yields exactly one result
// beat with the handle, an ok flag and the live count after the operation. One
// beat is worked on at a time, taken only while the sequencer is idle, and any
// wait for the result register to drain holds the sequencer. The result
// register loads as the sequencer returns to idle, ready for the next beat. The
// pace is set by the single registered read port and single write port of each
// table RAM, through which a free needs two dependent reads, a third read and
// three writes, two to the dense table. No clearing pass is needed after
// reset: a high-water mark of the live count tells which table entries have
// been written since reset. The user must write the capacity register only
// while idle; the block itself does not enforce it.
module dense_handle_allocator_top #(
    parameter int MAX_HANDLES = dha_pkg::MAX_HANDLES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // capacity register write
    input  logic                               cfg_wr_en,
    input  logic [dha_pkg::COUNT_W-1:0]        cfg_wr_data,
    // request beats
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // fields from bit 0: func[1:0], handle[11:2], position[21:12], zero fill
    input  logic [dha_pkg::IN_TDATA_W-1:0]     s_tdata,
    // result beats
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // fields from bit 0: handle_out[9:0], ok[10], live_count[21:11], zero fill
    output logic [dha_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    import dha_pkg::*;

    localparam int DEPTH = (MAX_HANDLES < HANDLE_SPACE) ? MAX_HANDLES : HANDLE_SPACE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

    dha_stat_t stat;
    dha_ctl_t  ctl;

    // input fields
    func_t                in_func;
    logic [HANDLE_W-1:0]  in_handle;
    logic [HANDLE_W-1:0]  in_position;

    // registers
    logic [COUNT_W-1:0]   cap_reg, cap_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   hw_reg, hw_next;
    logic [HANDLE_W-1:0]  h_reg, h_next;
    logic [HANDLE_W-1:0]  p_reg, p_next;
    logic [HANDLE_W-1:0]  pos_reg, pos_next;
    logic                 pre_reg, pre_next;
    logic [HANDLE_W-1:0]  res_handle_reg, res_handle_next;
    logic                 res_ok_reg, res_ok_next;
    logic                 out_valid_reg, out_valid_next;
    logic [HANDLE_W-1:0]  out_handle_reg, out_handle_next;
    logic                 out_ok_reg, out_ok_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;

    // table ports
    logic                 dense_we, hp_we;
    logic [AW-1:0]        dense_waddr, dense_raddr, hp_waddr, hp_raddr;
    logic [HANDLE_W-1:0]  dense_wdata, dense_rdata, hp_wdata, hp_rdata;

    // derived values
    logic [COUNT_W-1:0]   cap_eff;
    logic [COUNT_W-1:0]   count_m1;
    logic                 take;
    logic                 alloc_ok;
    logic [HANDLE_W-1:0]  alloc_got;
    logic                 read_ok;
    logic [HANDLE_W-1:0]  read_val;
    logic                 live;
    logic                 out_free;

    assign in_func     = func_t'(s_tdata[FUNC_W-1:0]);
    assign in_handle   = s_tdata[FUNC_W+HANDLE_W-1:FUNC_W];
    assign in_position = s_tdata[FUNC_W+2*HANDLE_W-1:FUNC_W+HANDLE_W];

    assign take     = s_tvalid && ctl.in_ready;
    assign s_tready = ctl.in_ready;
    assign out_free = !out_valid_reg || m_tready;

    // effective capacity and shared compares
    assign cap_eff   = (cap_reg > DEPTH_C) ? DEPTH_C : cap_reg;
    assign count_m1  = count_reg - COUNT_W'(1);
    assign alloc_ok  = (count_reg < cap_eff);
    assign alloc_got = (count_reg == hw_reg) ? count_reg[HANDLE_W-1:0] : dense_rdata;
    assign read_ok   = ({1'b0, p_reg} < cap_eff);
    assign read_val  = ({1'b0, p_reg} < hw_reg) ? dense_rdata : p_reg;
    assign live      = pre_reg && (dense_rdata == h_reg);

    // sequencer
    assign stat.take     = take;
    assign stat.func     = in_func;
    assign stat.live     = live;
    assign stat.out_free = out_free;

    dha_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // dense table: position to handle
    dha_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (DEPTH)
    ) u_dense (
        .clk     (clk),
        .wr_en   (dense_we),
        .wr_addr (dense_waddr),
        .wr_data (dense_wdata),
        .rd_addr (dense_raddr),
        .rd_data (dense_rdata)
    );

    // reverse table: handle to position
    dha_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (DEPTH)
    ) u_hpos (
        .clk     (clk),
        .wr_en   (hp_we),
        .wr_addr (hp_waddr),
        .wr_data (hp_wdata),
        .rd_addr (hp_raddr),
        .rd_data (hp_rdata)
    );

    // table read addresses
    assign hp_raddr = in_handle[AW-1:0];

    always_comb
    begin
        dense_raddr = '0;
        case (ctl.state)
            ST_IDLE:
            begin
                if (in_func == FN_ALLOC)
                begin
                    dense_raddr = count_reg[AW-1:0];
                end
                else
                begin
                    dense_raddr = in_position[AW-1:0];
                end
            end
            ST_POS:  dense_raddr = hp_rdata[AW-1:0];
            ST_CHK:  dense_raddr = count_m1[AW-1:0];
            default: dense_raddr = '0;
        endcase
    end

    // table writes
    always_comb
    begin
        dense_we    = 1'b0;
        dense_waddr = '0;
        dense_wdata = '0;
        hp_we       = 1'b0;
        hp_waddr    = '0;
        hp_wdata    = '0;
        case (ctl.state)
            ST_ALLOC:
            begin
                dense_we    = alloc_ok;
                dense_waddr = count_reg[AW-1:0];
                dense_wdata = alloc_got;
                hp_we       = alloc_ok;
                hp_waddr    = alloc_got[AW-1:0];
                hp_wdata    = count_reg[HANDLE_W-1:0];
            end
            ST_LAST:
            begin
                // last live handle moves into the freed slot
                dense_we    = 1'b1;
                dense_waddr = pos_reg[AW-1:0];
                dense_wdata = dense_rdata;
                hp_we       = 1'b1;
                hp_waddr    = dense_rdata[AW-1:0];
                hp_wdata    = pos_reg;
            end
            ST_TAIL:
            begin
                // freed handle parks just past the live ones
                dense_we    = 1'b1;
                dense_waddr = count_reg[AW-1:0];
                dense_wdata = h_reg;
            end
            default:
            begin
                dense_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        cap_next        = cap_reg;
        count_next      = count_reg;
        hw_next         = hw_reg;
        h_next          = h_reg;
        p_next          = p_reg;
        pos_next        = pos_reg;
        pre_next        = pre_reg;
        res_handle_next = res_handle_reg;
        res_ok_next     = res_ok_reg;

        if (cfg_wr_en)
        begin
            cap_next = cfg_wr_data;
        end

        if (take)
        begin
            h_next = in_handle;
            p_next = in_position;
        end

        case (ctl.state)
            ST_ALLOC:
            begin
                res_handle_next = '0;
                res_ok_next     = 1'b0;
                if (alloc_ok)
                begin
                    res_handle_next = alloc_got;
                    res_ok_next     = 1'b1;
                    count_next      = count_reg + COUNT_W'(1);
                    if (count_reg == hw_reg)
                    begin
                        hw_next = hw_reg + COUNT_W'(1);
                    end
                end
            end
            ST_READ:
            begin
                res_ok_next     = read_ok;
                res_handle_next = read_ok ? read_val : '0;
            end
            ST_POS:
            begin
                // reverse entries of handles below the high-water mark are written
                pos_next = hp_rdata;
                pre_next = ({1'b0, h_reg} < hw_reg) && ({1'b0, hp_rdata} < count_reg);
            end
            ST_CHK:
            begin
                res_handle_next = '0;
                res_ok_next     = live;
            end
            ST_LAST:
            begin
                count_next = count_m1;
            end
            default:
            begin
                res_ok_next = res_ok_reg;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_handle_next = out_handle_reg;
        out_ok_next     = out_ok_reg;
        out_count_next  = out_count_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctl.state == ST_DONE && out_free)
        begin
            out_valid_next  = 1'b1;
            out_handle_next = res_handle_reg;
            out_ok_next     = res_ok_reg;
            out_count_next  = count_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            hw_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            hw_reg        <= hw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        h_reg          <= h_next;
        p_reg          <= p_next;
        pos_reg        <= pos_next;
        pre_reg        <= pre_next;
        res_handle_reg <= res_handle_next;
        res_ok_reg     <= res_ok_next;
        out_handle_reg <= out_handle_next;
        out_ok_reg     <= out_ok_next;
        out_count_reg  <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - COUNT_W - 1 - HANDLE_W)'(0),
                       out_count_reg, out_ok_reg, out_handle_reg};

`ifndef SYNTHESIS
    // live count never passes the high-water mark
    a_count_le_hw: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hw_reg)
        else $error("live count above high-water mark");

    // high-water mark stays within the table
    a_hw_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg <= DEPTH_C)
        else $error("high-water mark beyond table depth");

    // live count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg)
                  || count_reg == $past(count_reg) + COUNT_W'(1)
                  || count_reg == $past(count_reg) - COUNT_W'(1)))
        else $error("live count jumped");

    // a finished operation always lands in the result register
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.state == ST_DONE && out_free) |=> m_tvalid)
        else $error("result lost");

    // no request is taken while the sequencer is busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.state != ST_IDLE) |-> !s_tready)
        else $error("request accepted while busy");
`endif

endmodule

[sv/dha_ram.sv]
`timescale 1ns / 1ps

module dha_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[sv/dha_seq.sv]
`timescale 1ns / 1ps

module dha_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  dha_pkg::dha_stat_t  stat,
    output dha_pkg::dha_ctl_t   ctl
);

    import dha_pkg::*;

    state_t state_reg, state_next;
    func_t  func_reg, func_next;

    // state and operation registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            func_reg  <= FN_ALLOC;
        end
        else
        begin
            state_reg <= state_next;
            func_reg  <= func_next;
        end
    end

    // latch the operation of an accepted beat
    always_comb
    begin
        func_next = func_reg;
        if (stat.take)
        begin
            func_next = stat.func;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (stat.take)
                begin
                    case (stat.func)
                        FN_ALLOC: state_next = ST_ALLOC;
                        FN_READ:  state_next = ST_READ;
                        default:  state_next = ST_POS;
                    endcase
                end
            end
            ST_ALLOC: state_next = ST_DONE;
            ST_READ:  state_next = ST_DONE;
            ST_POS:   state_next = ST_CHK;
            ST_CHK:
            begin
                if (func_reg == FN_FREE && stat.live)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LAST:  state_next = ST_TAIL;
            ST_TAIL:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl.state    = state_reg;
        ctl.func     = func_reg;
        ctl.in_ready = (state_reg == ST_IDLE);
    end

endmodule

[tb/handle_table_checker.sv]
`timescale 1ns / 1ps

module handle_table_checker #(
    parameter int MAX_HANDLES = dha_pkg::MAX_HANDLES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [dha_pkg::COUNT_W-1:0]        cfg_wr_data,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [dha_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [dha_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output int                                 mismatches,
    output int                                 outstanding,
    output logic [dha_pkg::COUNT_W-1:0]        live_count
);
    import dha_pkg::*;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic                ok;
        logic [COUNT_W-1:0]  live_count;
    } handle_reply_t;

    // shadow copy of the allocator tables
    logic [HANDLE_W-1:0] dense_tbl [HANDLE_SPACE];
    logic [HANDLE_W-1:0] slot_of [HANDLE_SPACE];
    logic [COUNT_W-1:0]  live_n;
    logic [COUNT_W-1:0]  cap_reg;
    handle_reply_t       replies_q [$];
    int                  err_total;

    // capacity clipped to the table depth and the handle space
    function automatic int usable_capacity();
        int c;
        c = cap_reg;
        if (c > MAX_HANDLES)
            c = MAX_HANDLES;
        if (c > HANDLE_SPACE)
            c = HANDLE_SPACE;
        return c;
    endfunction

    function automatic bit is_live(logic [HANDLE_W-1:0] h);
        int slot;
        if (h >= MAX_HANDLES)
            return 1'b0;
        slot = slot_of[h];
        if (slot >= live_n || slot >= MAX_HANDLES)
            return 1'b0;
        return dense_tbl[slot] == h;
    endfunction

    // apply one operation to the shadow tables and form its reply
    task automatic predict_handle_op(input func_t f, input logic [HANDLE_W-1:0] h,
                                     input logic [HANDLE_W-1:0] p,
                                     output handle_reply_t r);
        int                  cap_eff;
        int                  slot;
        int                  tail;
        logic [HANDLE_W-1:0] got;
        logic [HANDLE_W-1:0] mover;
        r = '0;
        cap_eff = usable_capacity();
        case (f)
            FN_ALLOC:
            begin
                if (live_n < cap_eff && live_n < MAX_HANDLES)
                begin
                    got = dense_tbl[live_n];
                    if (got < MAX_HANDLES)
                        slot_of[got] = HANDLE_W'(live_n);
                    live_n = live_n + 1'b1;
                    r.handle_out = got;
                    r.ok = 1'b1;
                end
            end
            FN_FREE:
            begin
                if (live_n > 0 && is_live(h))
                begin
                    // swap the freed handle with the last live one
                    slot = slot_of[h];
                    live_n = live_n - 1'b1;
                    tail = live_n;
                    mover = dense_tbl[tail];
                    dense_tbl[slot] = mover;
                    if (mover < MAX_HANDLES)
                        slot_of[mover] = HANDLE_W'(slot);
                    dense_tbl[tail] = h;
                    r.ok = 1'b1;
                end
            end
            FN_CHECK:
            begin
                r.ok = is_live(h);
            end
            default:
            begin
                if (p < cap_eff && p < MAX_HANDLES)
                begin
                    r.handle_out = dense_tbl[p];
                    r.ok = 1'b1;
                end
            end
        endcase
        r.live_count = live_n;
    endtask

    // track config, predict on request beats, compare on result beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        handle_reply_t seen;
        handle_reply_t want;
        handle_reply_t fresh;
        int i;
        if (!rst_n)
        begin
            for (i = 0; i < HANDLE_SPACE; i++)
            begin
                dense_tbl[i] = HANDLE_W'(i);
                slot_of[i] = '0;
            end
            live_n = '0;
            cap_reg = CAP_RESET;
            replies_q.delete();
            err_total = 0;
            mismatches <= 0;
            outstanding <= 0;
            live_count <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg = cfg_wr_data;

            // result beat first: it belongs to an earlier request
            if (m_tvalid && m_tready)
            begin
                seen.handle_out = m_tdata[9:0];
                seen.ok = m_tdata[10];
                seen.live_count = m_tdata[21:11];
                if (replies_q.size() == 0)
                begin
                    $error("result beat with no request waiting: handle_out %0d ok %0d live_count %0d",
                           seen.handle_out, seen.ok, seen.live_count);
                    err_total++;
                end
                else
                begin
                    want = replies_q.pop_front();
                    if (seen.handle_out !== want.handle_out)
                    begin
                        $error("handle_out: expected %0d, actual %0d",
                               want.handle_out, seen.handle_out);
                        err_total++;
                    end
                    if (seen.ok !== want.ok)
                    begin
                        $error("ok: expected %0d, actual %0d", want.ok, seen.ok);
                        err_total++;
                    end
                    if (seen.live_count !== want.live_count)
                    begin
                        $error("live_count: expected %0d, actual %0d",
                               want.live_count, seen.live_count);
                        err_total++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                predict_handle_op(func_t'(s_tdata[1:0]), s_tdata[11:2], s_tdata[21:12], fresh);
                replies_q.push_back(fresh);
            end

            mismatches <= err_total;
            outstanding <= replies_q.size();
            live_count <= live_n;
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import dha_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 16;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [COUNT_W-1:0]     cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int                     mismatches;
    int                     outstanding;
    logic [COUNT_W-1:0]     live_count;
    int unsigned            cycle_count;
    int                     stall_left;
    bit                     calm;

    dense_handle_allocator_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    handle_table_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .live_count  (live_count)
    );

    // clock
    initial
        clk = 1'b0;
    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side backpressure: mostly short stalls, a few long ones
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25)
                stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                          : $urandom_range(8, 30);
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // drive one request beat and wait until it is taken
    task automatic send_op(input func_t f, input logic [HANDLE_W-1:0] h,
                           input logic [HANDLE_W-1:0] p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, p, h, f};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // hold off requests until every reply is back
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_capacity(input logic [COUNT_W-1:0] value);
        wait_for_drain();
        repeat (8) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // random mix of operations; handles and positions mostly inside a window
    task automatic run_mix(input int n, input int window, input int alloc_w,
                           input int free_w, input int check_w);
        int                  r;
        func_t               f;
        logic [HANDLE_W-1:0] h;
        logic [HANDLE_W-1:0] p;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < alloc_w)
                f = FN_ALLOC;
            else if (r < alloc_w + free_w)
                f = FN_FREE;
            else if (r < alloc_w + free_w + check_w)
                f = FN_CHECK;
            else
                f = FN_READ;
            h = ($urandom_range(0, 9) < 8) ? HANDLE_W'($urandom_range(0, window - 1))
                                           : HANDLE_W'($urandom);
            p = ($urandom_range(0, 9) < 8) ? HANDLE_W'($urandom_range(0, window - 1))
                                           : HANDLE_W'($urandom);
            send_op(f, h, p);
            if ($urandom_range(0, 199) == 0)
                wait_for_drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        calm = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, reads at both ends, swap on free
        send_op(FN_FREE, 10'd0, 10'd0);
        send_op(FN_CHECK, 10'd0, 10'd1023);
        send_op(FN_READ, 10'd1023, 10'd0);
        send_op(FN_READ, 10'd0, 10'd1023);
        send_op(FN_ALLOC, 10'd1023, 10'd1023);
        send_op(FN_ALLOC, 10'd0, 10'd0);
        send_op(FN_ALLOC, 10'd512, 10'd341);
        send_op(FN_CHECK, 10'd1, 10'd0);
        send_op(FN_CHECK, 10'd1023, 10'd0);
        send_op(FN_FREE, 10'd5, 10'd0);
        send_op(FN_FREE, 10'd1, 10'd0);
        send_op(FN_READ, 10'd0, 10'd1);
        send_op(FN_ALLOC, 10'd0, 10'd0);
        send_op(FN_FREE, 10'd1023, 10'd0);
        send_op(FN_CHECK, 10'd0, 10'd0);

        // capacity lowered below the live count
        set_capacity(11'd2);
        send_op(FN_ALLOC, 10'd0, 10'd0);
        send_op(FN_CHECK, 10'd2, 10'd0);
        send_op(FN_FREE, 10'd2, 10'd0);
        send_op(FN_ALLOC, 10'd0, 10'd0);
        send_op(FN_FREE, 10'd0, 10'd0);
        send_op(FN_ALLOC, 10'd0, 10'd0);
        send_op(FN_READ, 10'd0, 10'd2);
        send_op(FN_READ, 10'd0, 10'd1);

        // zero capacity, then a value past the table depth
        set_capacity(11'd0);
        send_op(FN_ALLOC, 10'd0, 10'd0);
        send_op(FN_READ, 10'd0, 10'd0);
        send_op(FN_CHECK, 10'd1, 10'd0);
        set_capacity(11'd2047);
        send_op(FN_READ, 10'd0, 10'd1023);
        send_op(FN_ALLOC, 10'd0, 10'd0);

        // random phases over a range of capacities
        calm <= 1'b1;
        run_mix(60, 48, 35, 30, 20);
        calm <= 1'b0;
        set_capacity(11'd16);
        run_mix(110, 24, 40, 30, 15);
        set_capacity(11'd1);
        run_mix(50, 4, 35, 35, 15);
        set_capacity(11'd0);
        run_mix(40, 8, 30, 30, 20);
        set_capacity(11'd64);
        run_mix(110, 80, 50, 15, 20);
        set_capacity(11'd8);
        run_mix(90, 80, 25, 45, 15);

        // fill the whole table, then push past full
        set_capacity(11'd1024);
        calm <= 1'b1;
        while (live_count < 11'd1024)
            send_op(FN_ALLOC, HANDLE_W'($urandom), HANDLE_W'($urandom));
        repeat (3) send_op(FN_ALLOC, HANDLE_W'($urandom), HANDLE_W'($urandom));
        send_op(FN_READ, 10'd0, 10'd1023);
        send_op(FN_CHECK, 10'd1023, 10'd0);
        calm <= 1'b0;

        // shrink far below a full table, free mostly, then raise the capacity again
        set_capacity(11'd100);
        run_mix(110, 1024, 20, 50, 15);
        set_capacity(11'd5);
        run_mix(70, 1024, 20, 45, 15);
        set_capacity(11'd1000);
        run_mix(110, 1024, 35, 30, 20);

        // let everything settle, then report
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
sv/dha_pkg.sv
sv/dha_ram.sv
sv/dha_seq.sv
sv/dense_handle_allocator_top.sv
tb/handle_table_checker.sv
tb/tb.sv
